@@ rtl/core/zip_header_walker_unit_defines.svh @@
// Assertion macros used by the checker of the header walker.
`ifndef ZIP_HEADER_WALKER_UNIT_DEFINES_SVH
`define ZIP_HEADER_WALKER_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define ZHW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ZHW_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ZHW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/zhw_pkg.sv @@
// Shared types and constants of the ZIP header walker.
package zhw_pkg;

	localparam int OFFSET_BITS = 32;

	localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
	localparam logic [31:0] SIG_END     = 32'h06054b50;
	localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;

	localparam logic [5:0] LOCAL_LEN   = 6'd30;
	localparam logic [5:0] CENTRAL_LEN = 6'd46;
	localparam logic [5:0] SIG_LEN     = 6'd4;
	localparam logic [3:0] DESC_LEN    = 4'd12;
	localparam int         DESC_FLAG_BIT = 3;

	typedef enum logic [2:0] {
		KIND_ENTRY     = 3'd0,
		KIND_END       = 3'd1,
		KIND_BAD_FIRST = 3'd2,
		KIND_UNKNOWN   = 3'd3,
		KIND_TRUNC     = 3'd4
	} zhw_kind_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       final_byte;
	} zhw_item_t;

	typedef struct packed {
		zhw_kind_t   result_kind;
		logic [15:0] entry_number;
		logic [15:0] method_code;
		logic [31:0] packed_size;
		logic [31:0] unpacked_size;
		logic [15:0] name_length;
		logic [31:0] name_offset;
		logic [31:0] data_offset;
		logic [31:0] failed_signature;
	} zhw_result_t;

endpackage

@@ rtl/core/zhw_in_if.sv @@
// Byte channel carrying archive bytes with a last-byte mark.
interface zhw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       final_byte;

	modport source (output valid, output stream_byte, output final_byte, input ready);
	modport sink (input valid, input stream_byte, input final_byte, output ready);
	modport monitor (input valid, input ready, input stream_byte, input final_byte);
endinterface

@@ rtl/core/zhw_out_if.sv @@
// Result channel carrying entry, end and error words.
interface zhw_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [15:0] entry_number;
	logic [15:0] method_code;
	logic [31:0] packed_size;
	logic [31:0] unpacked_size;
	logic [15:0] name_length;
	logic [31:0] name_offset;
	logic [31:0] data_offset;
	logic [31:0] failed_signature;

	modport source (
		output valid, output result_kind, output entry_number, output method_code,
		output packed_size, output unpacked_size, output name_length,
		output name_offset, output data_offset, output failed_signature,
		input ready
	);
	modport sink (
		input valid, input result_kind, input entry_number, input method_code,
		input packed_size, input unpacked_size, input name_length,
		input name_offset, input data_offset, input failed_signature,
		output ready
	);
	modport monitor (
		input valid, input ready, input result_kind, input entry_number,
		input method_code, input packed_size, input unpacked_size,
		input name_length, input name_offset, input data_offset,
		input failed_signature
	);
endinterface

@@ rtl/core/zhw_in_stage.sv @@
// Input register: holds one accepted archive word until the parser takes it.
module zhw_in_stage
	import zhw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	zhw_in_if.sink    archive,
	input  logic      advance,
	output logic      valid_s1,
	output zhw_item_t item_s1
);

	logic accept;

	assign archive.ready = !valid_s1 || advance;
	assign accept        = archive.valid && archive.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.stream_byte <= archive.stream_byte;
			item_s1.final_byte  <= archive.final_byte;
		end
	end

endmodule

@@ rtl/core/zhw_parser.sv @@
// Record parser: signature matching, header field capture and skip counting.
module zhw_parser
	import zhw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  zhw_item_t   item,
	output logic        res_valid,
	output zhw_result_t res
);

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SIG,
		PH_LOCAL,
		PH_CENTRAL,
		PH_SKIP,
		PH_DONE
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [5:0]             count_q, count_d;
	logic [31:0]            sig_q, sig_d;
	logic [31:0]            word0_q, word0_d;
	logic [63:0]            word1_q, word1_d;
	logic [47:0]            word2_q, word2_d;
	logic [32:0]            skip_q, skip_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [15:0]            entries_q, entries_d;

	logic [OFFSET_BITS-1:0] offset_inc;
	logic [OFFSET_BITS-1:0] data_pos;
	logic [15:0]            nlen;
	logic [15:0]            xlen;
	logic [32:0]            skip_dec;
	logic [5:0]             count_inc;
	logic [1:0]             idx0;
	logic [2:0]             idx1;
	logic [1:0]             idx2l;
	logic [2:0]             idx2c;
	logic                   found;
	zhw_result_t            res_d;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		sig_d     = sig_q;
		word0_d   = word0_q;
		word1_d   = word1_q;
		word2_d   = word2_q;
		skip_d    = skip_q;
		entries_d = entries_q;
		found     = 1'b0;
		res_d     = '0;
		nlen      = '0;
		xlen      = '0;
		data_pos  = '0;

		count_inc  = count_q + 6'd1;
		offset_inc = offset_q + OFFSET_BITS'(1);
		offset_d   = offset_inc;
		idx0       = 2'(count_q - 6'd6);
		idx1       = 3'(count_q - 6'd18);
		idx2l      = 2'(count_q - 6'd26);
		idx2c      = 3'(count_q - 6'd28);
		skip_dec   = (skip_q != '0) ? skip_q - 33'd1 : skip_q;

		case (phase_q)
			PH_FIRST, PH_SIG: begin
				sig_d   = {item.stream_byte, sig_q[31:8]};
				count_d = count_inc;
				if (count_inc >= SIG_LEN) begin
					if (phase_q == PH_FIRST && sig_d != SIG_LOCAL) begin
						found                  = 1'b1;
						res_d.result_kind      = KIND_BAD_FIRST;
						res_d.failed_signature = sig_d;
						phase_d                = PH_DONE;
					end else if (sig_d == SIG_LOCAL) begin
						phase_d = PH_LOCAL;
					end else if (sig_d == SIG_CENTRAL) begin
						phase_d = PH_CENTRAL;
					end else if (sig_d == SIG_END) begin
						found             = 1'b1;
						res_d.result_kind = KIND_END;
						phase_d           = PH_DONE;
					end else begin
						found                  = 1'b1;
						res_d.result_kind      = KIND_UNKNOWN;
						res_d.failed_signature = sig_d;
						phase_d                = PH_DONE;
					end
				end
			end
			PH_LOCAL: begin
				if (count_q >= 6'd6 && count_q <= 6'd9) begin
					word0_d[idx0*8 +: 8] = item.stream_byte;
				end else if (count_q >= 6'd18 && count_q <= 6'd25) begin
					word1_d[idx1*8 +: 8] = item.stream_byte;
				end else if (count_q >= 6'd26 && count_q <= 6'd29) begin
					word2_d[idx2l*8 +: 8] = item.stream_byte;
				end
				count_d = count_inc;
				if (count_inc >= LOCAL_LEN) begin
					// Name and extra lengths of the header just completed, last byte merged.
					nlen                = word2_d[15:0];
					xlen                = word2_d[31:16];
					data_pos            = offset_inc + OFFSET_BITS'(32'(nlen))
						+ OFFSET_BITS'(32'(xlen));
					found               = 1'b1;
					res_d.result_kind   = KIND_ENTRY;
					res_d.entry_number  = entries_q;
					res_d.method_code   = word0_d[31:16];
					res_d.packed_size   = word1_d[31:0];
					res_d.unpacked_size = word1_d[63:32];
					res_d.name_length   = nlen;
					res_d.name_offset   = 32'(offset_inc);
					res_d.data_offset   = 32'(data_pos);
					if (entries_q != 16'hFFFF) begin
						entries_d = entries_q + 16'd1;
					end
					skip_d = 33'(word1_d[31:0]) + 33'(nlen) + 33'(xlen)
						+ (word0_d[DESC_FLAG_BIT] ? 33'(DESC_LEN) : 33'd0);
					if (skip_d != '0) begin
						phase_d = PH_SKIP;
						count_d = '0;
					end else begin
						phase_d = PH_SIG;
						count_d = '0;
						sig_d   = '0;
					end
				end
			end
			PH_CENTRAL: begin
				if (count_q >= 6'd28 && count_q <= 6'd33) begin
					word2_d[idx2c*8 +: 8] = item.stream_byte;
				end
				count_d = count_inc;
				if (count_inc >= CENTRAL_LEN) begin
					skip_d = 33'(word2_q[15:0]) + 33'(word2_q[31:16]) + 33'(word2_q[47:32]);
					if (skip_d != '0) begin
						phase_d = PH_SKIP;
						count_d = '0;
					end else begin
						phase_d = PH_SIG;
						count_d = '0;
						sig_d   = '0;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					phase_d = PH_SIG;
					count_d = '0;
					sig_d   = '0;
				end
			end
			default: begin
			end
		endcase

		// End of stream: flag a short stream, then rearm from scratch.
		if (item.final_byte) begin
			if (phase_q != PH_DONE && (!found || res_d.result_kind == KIND_ENTRY)) begin
				found             = 1'b1;
				res_d             = '0;
				res_d.result_kind = KIND_TRUNC;
			end
			phase_d   = PH_FIRST;
			count_d   = '0;
			sig_d     = '0;
			skip_d    = '0;
			offset_d  = '0;
			entries_d = '0;
		end
	end

	assign res_valid = found;
	assign res       = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			count_q   <= '0;
			sig_q     <= '0;
			skip_q    <= '0;
			offset_q  <= '0;
			entries_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			sig_q     <= sig_d;
			skip_q    <= skip_d;
			offset_q  <= offset_d;
			entries_q <= entries_d;
		end
	end

	// Header words are fully rewritten before every read.
	always_ff @(posedge clk) begin
		if (step) begin
			word0_q <= word0_d;
			word1_q <= word1_d;
			word2_q <= word2_d;
		end
	end

endmodule

@@ rtl/core/zhw_out_stage.sv @@
// Result register: holds one result word until the receiver takes it.
module zhw_out_stage
	import zhw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  zhw_result_t res,
	zhw_out_if.source   report,
	output logic        free
);

	logic        valid_q;
	zhw_result_t res_q;

	assign free = !valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (report.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign report.valid            = valid_q;
	assign report.result_kind      = res_q.result_kind;
	assign report.entry_number     = res_q.entry_number;
	assign report.method_code      = res_q.method_code;
	assign report.packed_size      = res_q.packed_size;
	assign report.unpacked_size    = res_q.unpacked_size;
	assign report.name_length      = res_q.name_length;
	assign report.name_offset      = res_q.name_offset;
	assign report.data_offset      = res_q.data_offset;
	assign report.failed_signature = res_q.failed_signature;

endmodule

@@ rtl/core/zip_header_walker_unit.sv @@
// Top level of the ZIP header walker: input register, parser, result register.
//
// Channel archive takes the archive one byte per word, in file order, with
// final_byte set on the last byte. Channel report gives at most one result
// word per byte: an entry for each local file header (on its 30th byte),
// an end word for the end-of-central-directory signature, or an error word
// (bad first signature, unknown signature, truncated stream).
// An accepted byte waits in the input register; the parser decodes it and its
// result, if any, loads into the result register when the byte advances.
// Throughput: one byte per cycle unless report stalls, every byte the same; the
// parser updates its record state from the registered byte in a single step.
// After an end or error word, bytes are dropped until the last byte; every
// last byte returns the parser to its reset state, so the next archive can
// follow at once.
// Reset (arst_n low) empties both registers and rearms the parser.
// When the receiver stalls, the result word holds and the parser stops with
// it, whether or not the next byte gives a result; the held byte waits in the
// input register and archive.ready drops until report is taken.
module zip_header_walker_unit
	import zhw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	zhw_in_if.sink    archive,
	zhw_out_if.source report
);

	logic        valid_s1;
	zhw_item_t   item_s1;
	logic        out_free;
	logic        advance;
	logic        res_valid;
	zhw_result_t res;

	// Advance the held byte whenever the result register can take a word.
	assign advance = valid_s1 && out_free;

	zhw_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.archive  (archive),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	zhw_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Load a result word only for bytes that produce one.
	zhw_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.report (report),
		.free   (out_free)
	);

endmodule

@@ rtl/core/zhw_checker.sv @@
// Port-level checker of the ZIP header walker, bound to the top level.
`include "zip_header_walker_unit_defines.svh"

module zhw_checker
	import zhw_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	zhw_in_if.sink    archive,
	zhw_out_if.source report
);

	`ZHW_ASSERT_NEXT(a_report_holds, report.valid && !report.ready, report.valid && $stable(report.result_kind) && $stable(report.data_offset), "result word changed while stalled")
	`ZHW_ASSERT_IMPL(a_no_entry_fields, report.valid && report.result_kind != KIND_ENTRY, report.entry_number == 16'd0 && report.method_code == 16'd0 && report.packed_size == 32'd0 && report.name_length == 16'd0 && report.data_offset == 32'd0, "entry fields set on a non-entry word")
	`ZHW_ASSERT_IMPL(a_sig_only_errors, report.valid && report.result_kind != KIND_BAD_FIRST && report.result_kind != KIND_UNKNOWN, report.failed_signature == 32'd0, "signature set on a word that is not a signature error")
	`ZHW_ASSERT_IMPL(a_data_after_name, report.valid && report.result_kind == KIND_ENTRY, 32'(report.data_offset - report.name_offset) >= 32'(report.name_length), "data offset lies inside the file name")

endmodule

bind zip_header_walker_unit zhw_checker u_zhw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.archive (archive),
	.report  (report)
);
